@@ rtl/core/nes_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nes_pkg: shared types and constants
// Field widths, register indexes and the row record that travels from the
// front end through the queue to the back end.
// ----------------------------------------------------------------------------
package nes_pkg;

  localparam int CNT_W      = 24;
  localparam int FREQ_W     = 16;
  localparam int BETA_W     = 32;
  localparam int SE_W       = 32;
  localparam int NEFF_W     = 33;
  localparam int ZMAG_W     = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // default depth of the queue between front and back end
  localparam int NES_QUEUE_DEPTH = 4;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIXED_MODE     = 2'd0,
    CFG_FIXED_CASES    = 2'd1,
    CFG_FIXED_CONTROLS = 2'd2
  } cfg_idx_t;

  // configuration seen by the front end
  typedef struct packed {
    logic             fixed_mode;
    logic [CNT_W-1:0] cases;
    logic [CNT_W-1:0] controls;
  } cfg_t;

  // classified row handed from front end to back end
  typedef struct packed {
    logic [NEFF_W-1:0] neff;
    logic              neff_valid;
    logic              std_ok;
    logic              neg;
    logic [ZMAG_W-1:0] zmag;
    logic [FREQ_W-1:0] freq;
    logic [BETA_W-1:0] beta;
    logic [SE_W-1:0]   se;
  } row_t;

endpackage

@@ rtl/core/nes_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nes_front: count selection, Neff and |z| division
// Takes one row per beat, forms cases*controls and the count sum, then runs
// the Neff and |beta|/se quotients through a shared restoring divider
// pipeline, one quotient bit per stage, and classifies the row.
// ----------------------------------------------------------------------------
module nes_front import nes_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CNT_W-1:0]  in_case_count,
  input  logic [CNT_W-1:0]  in_control_count,
  input  logic [FREQ_W-1:0] in_allele_freq,
  input  logic [BETA_W-1:0] in_beta_in,
  input  logic [SE_W-1:0]   in_se_in,
  output logic              row_valid,
  output row_t              row,
  input  logic              row_full
);

  localparam int DIV_STEPS = NEFF_W;
  localparam int LAST      = DIV_STEPS - 1;

  typedef struct packed {
    logic [24:0]       n_rem;
    logic [32:0]       n_low;
    logic [31:0]       z_rem;
    logic [32:0]       z_low;
    logic [24:0]       sum;
    logic              s_zero;
    logic              zsat;
    logic              neg;
    logic [FREQ_W-1:0] freq;
    logic [BETA_W-1:0] beta;
    logic [SE_W-1:0]   se;
  } dstage_t;

  // one restoring step for both quotients
  function automatic dstage_t div_step(dstage_t a);
    dstage_t     b;
    logic [25:0] nr;
    logic [32:0] zr;
    b  = a;
    nr = {a.n_rem, a.n_low[32]};
    zr = {a.z_rem, a.z_low[32]};
    b.n_low = {a.n_low[31:0], 1'b0};
    b.z_low = {a.z_low[31:0], 1'b0};
    if (nr >= {1'b0, a.sum}) begin
      b.n_rem    = 25'(nr - {1'b0, a.sum});
      b.n_low[0] = 1'b1;
    end else begin
      b.n_rem = nr[24:0];
    end
    if (zr >= {1'b0, a.se}) begin
      b.z_rem    = 32'(zr - {1'b0, a.se});
      b.z_low[0] = 1'b1;
    end else begin
      b.z_rem = zr[31:0];
    end
    return b;
  endfunction

  logic                 en;
  logic [CNT_W-1:0]     c_sel, k_sel;
  logic [31:0]          bmag;
  logic                 v0_r;
  logic [47:0]          prod0_r;
  logic [24:0]          sum0_r;
  logic [31:0]          bmag0_r;
  logic                 neg0_r;
  logic [FREQ_W-1:0]    f0_r;
  logic [BETA_W-1:0]    beta0_r;
  logic [SE_W-1:0]      se0_r;
  dstage_t              d_init;
  dstage_t              ds_r [DIV_STEPS];
  logic [DIV_STEPS-1:0] dv_r;
  logic [NEFF_W-1:0]    neff;

  // the whole front moves unless a finished row cannot enter the queue
  assign en       = !(dv_r[LAST] && row_full);
  assign in_stall = !en;

  // count selection and beta magnitude
  assign c_sel = cfg.fixed_mode ? cfg.cases    : in_case_count;
  assign k_sel = cfg.fixed_mode ? cfg.controls : in_control_count;
  assign bmag  = in_beta_in[31] ? 32'(~in_beta_in + 32'd1) : in_beta_in;

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod0_r <= c_sel * k_sel;
      sum0_r  <= {1'b0, c_sel} + {1'b0, k_sel};
      bmag0_r <= bmag;
      neg0_r  <= in_beta_in[31];
      f0_r    <= in_allele_freq;
      beta0_r <= in_beta_in;
      se0_r   <= in_se_in;
    end
  end

  // divider start: numerators are c*k*1024 and |beta|*65536
  always_comb begin
    d_init.n_rem  = prod0_r[47:23];
    d_init.n_low  = {prod0_r[22:0], 10'd0};
    d_init.z_rem  = {17'd0, bmag0_r[31:17]};
    d_init.z_low  = {bmag0_r[16:0], 16'd0};
    d_init.sum    = sum0_r;
    d_init.s_zero = (sum0_r == 25'd0);
    d_init.zsat   = ({15'd0, bmag0_r[31:15]} >= se0_r);
    d_init.neg    = neg0_r;
    d_init.freq   = f0_r;
    d_init.beta   = beta0_r;
    d_init.se     = se0_r;
  end

  // divider stages
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j] <= 1'b0;
      end else if (en) begin
        if (j == 0) begin
          dv_r[j] <= v0_r;
        end else begin
          dv_r[j] <= dv_r[(j == 0) ? 0 : j-1];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (j == 0) begin
          ds_r[j] <= div_step(d_init);
        end else begin
          ds_r[j] <= div_step(ds_r[(j == 0) ? 0 : j-1]);
        end
      end
    end
  end

  // classification of the finished row
  assign neff      = ds_r[LAST].s_zero ? '0 : ds_r[LAST].n_low;
  assign row_valid = dv_r[LAST];

  always_comb begin
    row.neff       = neff;
    row.neff_valid = (neff != '0);
    row.std_ok     = (neff != '0) && (ds_r[LAST].freq != '0) && (ds_r[LAST].se != '0);
    row.neg        = ds_r[LAST].neg;
    row.zmag       = ds_r[LAST].zsat ? {ZMAG_W{1'b1}} : ds_r[LAST].z_low[ZMAG_W-1:0];
    row.freq       = ds_r[LAST].freq;
    row.beta       = ds_r[LAST].beta;
    row.se         = ds_r[LAST].se;
  end

endmodule

@@ rtl/core/nes_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nes_queue: row queue between front and back end
// Small first-in first-out store of classified rows so that either side can
// stall without holding up the other.
// ----------------------------------------------------------------------------
module nes_queue import nes_pkg::*; #(
  parameter int DEPTH = NES_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  row_t push_data,
  output logic full,
  input  logic pop,
  output row_t pop_data,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  row_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          push, pull;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign push     = push_valid && !full;
  assign pull     = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr_r + 1'b1);
      end
      if (pull) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr_r + 1'b1);
      end
      if (push && !pull) begin
        count_r <= CW'(count_r + 1'b1);
      end else if (pull && !push) begin
        count_r <= CW'(count_r - 1'b1);
      end
    end
  end

endmodule

@@ rtl/core/nes_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nes_back: standardisation pipeline
// Forms T = Neff*2^24 + z^2 and G = 2f(1-f), multiplies them, takes the
// reciprocal of the product one bit per stage, the square root two bits per
// stage, scales z and saturates into the output register.
// ----------------------------------------------------------------------------
module nes_back import nes_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  row_t              head,
  input  logic              head_valid,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [NEFF_W-1:0] out_neff,
  output logic              out_neff_valid,
  output logic              out_std_ok,
  output logic [BETA_W-1:0] out_beta_out,
  output logic [SE_W-1:0]   out_se_out
);

  localparam int RECIP_STEPS = 64;
  localparam int SQRT_STEPS  = 32;
  localparam logic [95:0] RECIP_ONE = 96'h1_0000_0000;

  typedef struct packed {
    logic              std_ok;
    logic [NEFF_W-1:0] neff;
    logic              neff_valid;
    logic              neg;
    logic [ZMAG_W-1:0] zmag;
    logic [BETA_W-1:0] beta;
    logic [SE_W-1:0]   se;
  } carry_t;

  typedef struct packed {
    logic [95:0] rem;
    logic [95:0] p;
    logic [63:0] q;
    logic        sat;
    carry_t      c;
  } rstage_t;

  typedef struct packed {
    logic [63:0] x;
    logic [33:0] rem;
    logic [31:0] root;
    carry_t      c;
  } sstage_t;

  // one quotient bit of 2^96 / P
  function automatic rstage_t recip_step(rstage_t a);
    rstage_t     b;
    logic [95:0] r2;
    b  = a;
    r2 = {a.rem[94:0], 1'b0};
    if (r2 >= a.p) begin
      b.rem = r2 - a.p;
      b.q   = {a.q[62:0], 1'b1};
    end else begin
      b.rem = r2;
      b.q   = {a.q[62:0], 1'b0};
    end
    return b;
  endfunction

  // one root bit of the integer square root
  function automatic sstage_t sqrt_step(sstage_t a);
    sstage_t     b;
    logic [35:0] r;
    logic [35:0] trial;
    b     = a;
    r     = {a.rem, a.x[63:62]};
    trial = {2'b00, a.root, 2'b01};
    b.x   = {a.x[61:0], 2'b00};
    if (r >= trial) begin
      b.rem  = 34'(r - trial);
      b.root = {a.root[30:0], 1'b1};
    end else begin
      b.rem  = r[33:0];
      b.root = {a.root[30:0], 1'b0};
    end
    return b;
  endfunction

  logic                   en;
  carry_t                 head_c;
  logic [16:0]            fc;
  logic [32:0]            gp;
  // product stages
  logic                   v1_r, v2_r, v3_r, v4_r;
  carry_t                 c1_r, c2_r, c3_r, c4_r;
  logic [61:0]            zz1_r;
  logic [31:0]            g1_r, g2_r;
  logic [63:0]            t2_r;
  logic [63:0]            pl3_r, ph3_r;
  logic [95:0]            p4_r;
  // reciprocal and root stages
  rstage_t                r_init;
  rstage_t                rs_r [RECIP_STEPS];
  logic [RECIP_STEPS-1:0] rv_r;
  sstage_t                s_init;
  sstage_t                ss_r [SQRT_STEPS];
  logic [SQRT_STEPS-1:0]  sv_r;
  // scaling and output
  logic                   vm_r;
  carry_t                 cm_r;
  logic [31:0]            root_m_r;
  logic [62:0]            bn_m_r;
  logic [46:0]            bn;
  logic [31:0]            bmag_sat;
  logic [BETA_W-1:0]      beta_nxt;
  logic [SE_W-1:0]        se_nxt;
  logic                   out_valid_r;
  logic [NEFF_W-1:0]      out_neff_r;
  logic                   out_neff_valid_r;
  logic                   out_std_ok_r;
  logic [BETA_W-1:0]      out_beta_r;
  logic [SE_W-1:0]        out_se_r;

  // the back end moves whenever the output register is free or being taken
  assign en  = !(out_valid_r && out_stall);
  assign pop = en && head_valid;

  always_comb begin
    head_c.std_ok     = head.std_ok;
    head_c.neff       = head.neff;
    head_c.neff_valid = head.neff_valid;
    head_c.neg        = head.neg;
    head_c.zmag       = head.zmag;
    head_c.beta       = head.beta;
    head_c.se         = head.se;
  end

  // f*(65536-f); doubled on the way into the register
  assign fc = 17'h1_0000 - {1'b0, head.freq};
  assign gp = head.freq * fc;

  // control of the product stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= head_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // z^2 and G, then T, then partial products of G*T, then P
  always_ff @(posedge clk) begin
    if (en) begin
      c1_r  <= head_c;
      zz1_r <= head.zmag * head.zmag;
      g1_r  <= {gp[30:0], 1'b0};
      c2_r  <= c1_r;
      g2_r  <= g1_r;
      t2_r  <= {7'd0, c1_r.neff, 24'd0} + {2'd0, zz1_r};
      c3_r  <= c2_r;
      pl3_r <= t2_r[31:0] * g2_r;
      ph3_r <= t2_r[63:32] * g2_r;
      c4_r  <= c3_r;
      p4_r  <= {ph3_r, 32'd0} + {32'd0, pl3_r};
    end
  end

  // reciprocal start: remainder 2^32 before the first quotient bit
  always_comb begin
    r_init.rem = RECIP_ONE;
    r_init.p   = p4_r;
    r_init.q   = '0;
    r_init.sat = (p4_r <= RECIP_ONE);
    r_init.c   = c4_r;
  end

  for (genvar j = 0; j < RECIP_STEPS; j++) begin : g_recip
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rv_r[j] <= 1'b0;
      end else if (en) begin
        if (j == 0) begin
          rv_r[j] <= v4_r;
        end else begin
          rv_r[j] <= rv_r[(j == 0) ? 0 : j-1];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (j == 0) begin
          rs_r[j] <= recip_step(r_init);
        end else begin
          rs_r[j] <= recip_step(rs_r[(j == 0) ? 0 : j-1]);
        end
      end
    end
  end

  // root start: an overflowed reciprocal reads as all ones
  always_comb begin
    s_init.x    = rs_r[RECIP_STEPS-1].sat ? '1 : rs_r[RECIP_STEPS-1].q;
    s_init.rem  = '0;
    s_init.root = '0;
    s_init.c    = rs_r[RECIP_STEPS-1].c;
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[j] <= 1'b0;
      end else if (en) begin
        if (j == 0) begin
          sv_r[j] <= rv_r[RECIP_STEPS-1];
        end else begin
          sv_r[j] <= sv_r[(j == 0) ? 0 : j-1];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (j == 0) begin
          ss_r[j] <= sqrt_step(s_init);
        end else begin
          ss_r[j] <= sqrt_step(ss_r[(j == 0) ? 0 : j-1]);
        end
      end
    end
  end

  // beta' magnitude: |z| * se'
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (en) begin
      vm_r <= sv_r[SQRT_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cm_r     <= ss_r[SQRT_STEPS-1].c;
      root_m_r <= ss_r[SQRT_STEPS-1].root;
      bn_m_r   <= ss_r[SQRT_STEPS-1].c.zmag * ss_r[SQRT_STEPS-1].root;
    end
  end

  // saturation, sign and pass-through selection
  assign bn = bn_m_r[62:16];

  always_comb begin
    if (cm_r.neg) begin
      bmag_sat = (bn > 47'h8000_0000) ? 32'h8000_0000 : bn[31:0];
    end else begin
      bmag_sat = (bn > 47'h7FFF_FFFF) ? 32'h7FFF_FFFF : bn[31:0];
    end
    if (!cm_r.std_ok) begin
      beta_nxt = cm_r.beta;
      se_nxt   = cm_r.se;
    end else begin
      beta_nxt = cm_r.neg ? 32'(~bmag_sat + 32'd1) : bmag_sat;
      se_nxt   = root_m_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_neff_r       <= cm_r.neff;
      out_neff_valid_r <= cm_r.neff_valid;
      out_std_ok_r     <= cm_r.std_ok;
      out_beta_r       <= beta_nxt;
      out_se_r         <= se_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_neff       = out_neff_r;
  assign out_neff_valid = out_neff_valid_r;
  assign out_std_ok     = out_std_ok_r;
  assign out_beta_out   = out_beta_r;
  assign out_se_out     = out_se_r;

endmodule

@@ rtl/core/neff_and_effect_standardizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neff_and_effect_standardizer: effective sample size and standardised beta
// Top level: configuration registers, front end, row queue and back end.
// ----------------------------------------------------------------------------
// Takes one variant row per clock and returns one result beat per row, in
// order, at a sustained rate of one per clock while the result side keeps
// taking. A row passes through the front end (input stage plus a 33-stage
// divider for Neff and |z|), the queue and the back end, whose depth is set
// mainly by the 64-stage reciprocal and 32-stage square root.
// Stalls on the result side fill the queue before the input side is held.
// Configuration writes are taken at any time but are meant for an idle block.
// ----------------------------------------------------------------------------
module neff_and_effect_standardizer import nes_pkg::*; #(
  parameter int QUEUE_DEPTH = NES_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CNT_W-1:0]      in_case_count,
  input  logic [CNT_W-1:0]      in_control_count,
  input  logic [FREQ_W-1:0]     in_allele_freq,
  input  logic signed [BETA_W-1:0] in_beta_in,
  input  logic [SE_W-1:0]       in_se_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [NEFF_W-1:0]     out_neff,
  output logic                  out_neff_valid,
  output logic                  out_std_ok,
  output logic signed [BETA_W-1:0] out_beta_out,
  output logic [SE_W-1:0]       out_se_out
);

  cfg_t              cfg_r;
  logic              row_valid;
  row_t              row;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;
  row_t              q_head;
  logic [BETA_W-1:0] beta_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FIXED_MODE:     cfg_r.fixed_mode <= cfg_wdata[0];
        CFG_FIXED_CASES:    cfg_r.cases      <= cfg_wdata[CNT_W-1:0];
        CFG_FIXED_CONTROLS: cfg_r.controls   <= cfg_wdata[CNT_W-1:0];
        default:            cfg_r            <= cfg_r;
      endcase
    end
  end

  nes_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_case_count    (in_case_count),
    .in_control_count (in_control_count),
    .in_allele_freq   (in_allele_freq),
    .in_beta_in       (in_beta_in),
    .in_se_in         (in_se_in),
    .row_valid        (row_valid),
    .row              (row),
    .row_full         (q_full)
  );

  nes_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (row_valid),
    .push_data  (row),
    .full       (q_full),
    .pop        (q_pop),
    .pop_data   (q_head),
    .empty      (q_empty)
  );

  nes_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_head),
    .head_valid     (!q_empty),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_neff       (out_neff),
    .out_neff_valid (out_neff_valid),
    .out_std_ok     (out_std_ok),
    .out_beta_out   (beta_out),
    .out_se_out     (out_se_out)
  );

  assign out_beta_out = beta_out;

endmodule

@@ dv/tb_neff_and_effect_standardizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_neff_and_effect_standardizer: self-checking bench for the standardiser
// Drives variant rows through the valid/stall channel under several register
// settings, predicts Neff and the standardised beta/se per row in bit-exact
// fixed point, and compares every result beat in order. Both sides idle and
// stall at random; one long result hold-off forces the input side to stall.
// ----------------------------------------------------------------------------
module tb_neff_and_effect_standardizer;
  import nes_pkg::*;

  typedef struct {
    logic [CNT_W-1:0]  cases;
    logic [CNT_W-1:0]  controls;
    logic [FREQ_W-1:0] freq;
    logic [BETA_W-1:0] beta;
    logic [SE_W-1:0]   se;
  } variant_t;

  typedef struct {
    logic [NEFF_W-1:0] neff;
    logic              neff_valid;
    logic              std_ok;
    logic [BETA_W-1:0] beta;
    logic [SE_W-1:0]   se;
  } stdres_t;

  typedef struct {
    variant_t row;
    bit       typed;
    stdres_t  res;
  } drow_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CNT_W-1:0] in_case_count = '0;
  logic [CNT_W-1:0] in_control_count = '0;
  logic [FREQ_W-1:0] in_allele_freq = '0;
  logic signed [BETA_W-1:0] in_beta_in = '0;
  logic [SE_W-1:0] in_se_in = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [NEFF_W-1:0] out_neff;
  logic out_neff_valid;
  logic out_std_ok;
  logic signed [BETA_W-1:0] out_beta_out;
  logic [SE_W-1:0] out_se_out;

  // shadow of the register file
  logic             sh_fixed_mode = 1'b0;
  logic [CNT_W-1:0] sh_cases = '0;
  logic [CNT_W-1:0] sh_controls = '0;

  stdres_t pending_results[$];
  int      n_errors = 0;
  int      n_results = 0;
  bit      quiet_mode = 1'b0;

  neff_and_effect_standardizer u_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] res, bit_v;
    res = '0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v >>= 2;
    while (bit_v != 0) begin
      if (x >= res + bit_v) begin
        x -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  // bit-exact Neff and standardised effect for one row
  function automatic stdres_t standardise(input variant_t r);
    stdres_t o;
    logic [63:0]  c, k, s, neff, bmag, zmag, t, g, q, sen, bn;
    logic [127:0] p;
    logic [128:0] quo;
    logic         neg;
    c = sh_fixed_mode ? 64'(sh_cases) : 64'(r.cases);
    k = sh_fixed_mode ? 64'(sh_controls) : 64'(r.controls);
    s = c + k;
    neff = (s != 0) ? ((4 * c * k) << 8) / s : 64'd0;
    o.neff = neff[NEFF_W-1:0];
    o.neff_valid = (neff != 0);
    o.std_ok = o.neff_valid && r.freq != 0 && r.se != 0;
    o.beta = r.beta;
    o.se = r.se;
    if (!o.std_ok) return o;
    neg = r.beta[31];
    bmag = neg ? 64'(-r.beta) : 64'(r.beta);
    if (neg && bmag[31:0] == 0) bmag = 64'h8000_0000;
    bmag = {32'd0, bmag[31:0]};
    if (neg && bmag == 0) bmag = 64'h8000_0000;
    zmag = (bmag << 16) / 64'(r.se);
    if (zmag > 64'h7FFF_FFFF) zmag = 64'h7FFF_FFFF;
    t = (neff << 24) + zmag * zmag;
    g = 2 * 64'(r.freq) * (64'd65536 - 64'(r.freq));
    p = 128'(t) * 128'(g);
    quo = (129'd1 << 96) / 129'(p);
    q = (quo > 129'h0_FFFF_FFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF_FFFF : quo[63:0];
    sen = isqrt64(q);
    if (sen > 64'hFFFF_FFFF) sen = 64'hFFFF_FFFF;
    bn = (zmag * sen) >> 16;
    if (neg) begin
      if (bn > 64'h8000_0000) bn = 64'h8000_0000;
      bn = -bn;
    end else if (bn > 64'h7FFF_FFFF) begin
      bn = 64'h7FFF_FFFF;
    end
    o.beta = bn[31:0];
    o.se = sen[31:0];
    return o;
  endfunction

  function automatic int gap_len();
    int r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // mostly well-formed rows, some degenerate ones
  function automatic variant_t random_row();
    variant_t r;
    int kind;
    kind = $urandom_range(0, 19);
    r.cases = CNT_W'($urandom) >> $urandom_range(0, 23);
    r.controls = CNT_W'($urandom) >> $urandom_range(0, 23);
    r.freq = FREQ_W'($urandom);
    r.beta = $urandom;
    r.beta = $signed(r.beta) >>> $urandom_range(0, 31);
    r.se = $urandom >> $urandom_range(0, 31);
    case (kind)
      0: r.freq = '0;
      1: r.se = '0;
      2: r.cases = '0;
      3: r.controls = '0;
      4: begin
        r.cases = CNT_W'($urandom);
        r.controls = CNT_W'($urandom);
        r.beta = $urandom;
        r.se = $urandom;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FIXED_MODE:     sh_fixed_mode = val[0];
      CFG_FIXED_CASES:    sh_cases = val;
      CFG_FIXED_CONTROLS: sh_controls = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // offer one row and hold it until taken; result stays queued from acceptance
  task automatic send_row(input variant_t r, input bit typed, input stdres_t res);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_case_count <= r.cases;
    in_control_count <= r.controls;
    in_allele_freq <= r.freq;
    in_beta_in <= r.beta;
    in_se_in <= r.se;
    do @(posedge clk); while (in_stall);
    pending_results.insert(pending_results.size(), typed ? res : standardise(r));
  endtask

  task automatic drain();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
  endtask

  task automatic random_phase(input int n);
    stdres_t dummy;
    dummy = '{default: '0};
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) quiet_mode = ($urandom_range(0, 3) == 0);
      send_row(random_row(), 1'b0, dummy);
    end
    quiet_mode = 1'b0;
  endtask

  // receiver: random stalls with one long hold-off
  initial begin
    bit held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!held && n_results >= 100) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (1500) @(posedge clk);
      end
      if (quiet_mode) out_stall <= 1'b0;
      else if ($urandom_range(0, 99) < 3) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 40)) @(posedge clk);
        out_stall <= 1'b0;
      end else out_stall <= ($urandom_range(0, 99) < 25);
    end
  end

  // result checker
  always @(posedge clk) begin
    stdres_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        n_errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_neff !== e.neff) begin
          $error("neff: exp %h got %h", e.neff, out_neff); n_errors++;
        end
        if (out_neff_valid !== e.neff_valid) begin
          $error("neff_valid: exp %b got %b", e.neff_valid, out_neff_valid); n_errors++;
        end
        if (out_std_ok !== e.std_ok) begin
          $error("std_ok: exp %b got %b", e.std_ok, out_std_ok); n_errors++;
        end
        if (out_beta_out !== e.beta) begin
          $error("beta_out: exp %h got %h", e.beta, out_beta_out); n_errors++;
        end
        if (out_se_out !== e.se) begin
          $error("se_out: exp %h got %h", e.se, out_se_out); n_errors++;
        end
      end
    end
  end

  // stimulus
  initial begin
    drow_t dir[$];
    stdres_t none;
    none = '{default: '0};
    // cases, controls, freq, beta, se | typed result
    dir = '{
      '{'{24'd0, 24'd0, 16'h8000, 32'h0001_0000, 32'h0000_8000}, 1,
        '{33'd0, 1'b0, 1'b0, 32'h0001_0000, 32'h0000_8000}},
      '{'{24'd0, 24'd500, 16'h4000, 32'hFFFF_0000, 32'h0001_0000}, 1,
        '{33'd0, 1'b0, 1'b0, 32'hFFFF_0000, 32'h0001_0000}},
      '{'{24'd1, 24'd1, 16'h0000, 32'h1234_5678, 32'h0000_1000}, 1,
        '{33'd512, 1'b1, 1'b0, 32'h1234_5678, 32'h0000_1000}},
      '{'{24'd1, 24'd1, 16'h8000, 32'h8000_0000, 32'h0000_0000}, 1,
        '{33'd512, 1'b1, 1'b0, 32'h8000_0000, 32'h0000_0000}},
      '{'{24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF}, 0, none},
      '{'{24'hFFFFFF, 24'hFFFFFF, 16'h0001, 32'h8000_0000, 32'h0000_0001}, 0, none},
      '{'{24'd1, 24'd1, 16'h0001, 32'h0000_0000, 32'h0000_0001}, 0, none},
      '{'{24'd1, 24'hFFFFFF, 16'h8000, 32'h7FFF_FFFF, 32'h0000_0001}, 0, none},
      '{'{24'd1000, 24'd3000, 16'h1999, 32'h0000_3000, 32'h0000_1000}, 0, none},
      '{'{24'd1000, 24'd3000, 16'h1999, 32'hFFFF_D000, 32'h0000_1000}, 0, none},
      '{'{24'd5000, 24'd5000, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 0, none},
      '{'{24'd20, 24'd7, 16'h0100, 32'h0000_0001, 32'h0001_0000}, 0, none}
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir[i]) send_row(dir[i].row, dir[i].typed, dir[i].res);
    random_phase(400);
    drain();
    // fixed mode at the top of the count range
    cfg_write(CFG_FIXED_CASES, 24'hFFFFFF);
    cfg_write(CFG_FIXED_CONTROLS, 24'hFFFFFF);
    cfg_write(CFG_FIXED_MODE, 24'd1);
    random_phase(250);
    drain();
    // fixed mode, both counts zero
    cfg_write(CFG_FIXED_CASES, 24'd0);
    cfg_write(CFG_FIXED_CONTROLS, 24'd0);
    random_phase(150);
    drain();
    // fixed mode, lopsided and mid-range counts
    cfg_write(CFG_FIXED_CASES, 24'd1);
    random_phase(150);
    drain();
    cfg_write(CFG_FIXED_CASES, CFG_DATA_W'($urandom));
    cfg_write(CFG_FIXED_CONTROLS, CFG_DATA_W'($urandom));
    random_phase(250);
    drain();
    // back to per-row counts
    cfg_write(CFG_FIXED_MODE, 24'd0);
    random_phase(300);
    drain();
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      n_errors++;
    end
    if (n_errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
